>>> hw/rtl/bpda_pkg.sv
// ----------------------------------------------------------------------------
// bpda_pkg
// Shared types, codes and helpers for the bounded priority deque admission
// block.
// ----------------------------------------------------------------------------
package bpda_pkg;

  localparam int DEPTH       = 16;
  localparam int MAX_WORKERS = 8;
  localparam int TAG_WIDTH   = 16;

  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ACT_W   = $clog2(MAX_WORKERS + 1);
  localparam int CAP_W   = 5;
  localparam int WRK_W   = 4;
  localparam int CFG_W   = 5;
  localparam int FUNC_W  = 3;
  localparam int STAT_W  = 4;

  typedef enum logic [FUNC_W-1:0] {
    FN_SUBMIT_BACK      = 3'd0,
    FN_SUBMIT_FRONT     = 3'd1,
    FN_SUBMIT_SUPERSEDE = 3'd2,
    FN_TAKE             = 3'd3,
    FN_DONE             = 3'd4,
    FN_START            = 3'd5,
    FN_STOP             = 3'd6
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_ACCEPTED  = 4'd0,
    ST_FULL      = 4'd1,
    ST_STOPPING  = 4'd2,
    ST_TAKEN     = 4'd3,
    ST_EMPTY     = 4'd4,
    ST_CANCELLED = 4'd5,
    ST_STARTED   = 4'd6,
    ST_OK        = 4'd7,
    ST_BUSY      = 4'd8
  } status_t;

  typedef enum logic {
    CFG_CAPACITY = 1'b0,
    CFG_WORKERS  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic                 cancel;
    logic [TAG_WIDTH-1:0] tag;
  } entry_t;

  // ring position base + off, both below DEPTH
  function automatic logic [PTR_W-1:0] slot(input logic [PTR_W-1:0] base,
                                            input logic [PTR_W-1:0] off);
    logic [PTR_W:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (PTR_W+1)'(DEPTH)) s = s - (PTR_W+1)'(DEPTH);
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] prev_slot(input logic [PTR_W-1:0] base);
    logic [PTR_W-1:0] p;
    if (base == '0) p = PTR_W'(DEPTH - 1);
    else            p = base - 1'b1;
    return p;
  endfunction

endpackage

>>> hw/rtl/bounded_priority_deque_admission.sv
// ----------------------------------------------------------------------------
// bounded_priority_deque_admission
// Bounded task deque with front/back/superseding submit, worker-limited
// take, done, start and a flushing stop.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | word
//  in_     | input     | in_valid / in_ready | func, task_tag, has_cancel
//  out_    | output    | out_valid/out_ready | status, tag, counts, last
//  cfg_    | input     | cfg_we              | index, data
//
//  Submit, done, start and every refused request are answered from the idle
//  state. Take and superseding submit on a full queue make one read of the
//  entry store; stop answers directly on an empty queue, else it walks the
//  store, one read per queued entry.
//  The next word is taken once the block is idle and the output register is
//  free or being emptied; a stalled output holds the sequencer whenever it has a word to emit.
//  Synchronous reset; the store needs no clearing pass.
// ----------------------------------------------------------------------------
module bounded_priority_deque_admission
  import bpda_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [TAG_WIDTH-1:0] in_task_tag,
  input  logic                 in_has_cancel,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STAT_W-1:0]    out_status,
  output logic [TAG_WIDTH-1:0] out_tag,
  output logic [CNT_W-1:0]     out_queued_count,
  output logic [ACT_W-1:0]     out_active_count,
  output logic                 out_accepting,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAKE,
    S_EVICT,
    S_ACCEPT,
    S_WALK_RD,
    S_WALK_CHK,
    S_FINAL
  } state_t;

  state_t               state_r, state_nxt;
  logic [PTR_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [ACT_W-1:0]     active_r, active_nxt;
  logic                 started_r, started_nxt;
  logic                 admit_r, admit_nxt;
  logic                 halted_r, halted_nxt;
  logic [CAP_W-1:0]     cap_r, cap_nxt;
  logic [WRK_W-1:0]     wrk_r, wrk_nxt;
  logic [PTR_W-1:0]     walk_base_r, walk_base_nxt;
  logic [CNT_W-1:0]     walk_cnt_r, walk_cnt_nxt;
  logic [CNT_W-1:0]     walk_idx_r, walk_idx_nxt;

  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [TAG_WIDTH-1:0] out_tag_r, out_tag_nxt;
  logic [CNT_W-1:0]     out_queued_r, out_queued_nxt;
  logic [ACT_W-1:0]     out_active_r, out_active_nxt;
  logic                 out_accepting_r, out_accepting_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 mem_we, mem_re;
  logic [PTR_W-1:0]     mem_waddr, mem_raddr;
  entry_t               mem_wdata, mem_rdata;

  logic                 out_free, accept;
  logic [CNT_W-1:0]     eff_cap;
  logic [ACT_W-1:0]     eff_wrk;
  logic [CNT_W-1:0]     count_m1;
  logic [CNT_W-1:0]     walk_idx_p1;
  logic                 emit, emit_last;
  status_t              emit_status;
  logic [TAG_WIDTH-1:0] emit_tag;
  entry_t               in_entry;

  bpda_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign in_entry = '{cancel: in_has_cancel, tag: in_task_tag};
  assign count_m1 = count_r - 1'b1;
  assign walk_idx_p1 = walk_idx_r + 1'b1;

  always_comb begin
    if (cap_r == '0)                     eff_cap = CNT_W'(1);
    else if (cap_r > CAP_W'(DEPTH))      eff_cap = CNT_W'(DEPTH);
    else                                 eff_cap = CNT_W'(cap_r);
    if (wrk_r == '0)                     eff_wrk = ACT_W'(1);
    else if (wrk_r > WRK_W'(MAX_WORKERS)) eff_wrk = ACT_W'(MAX_WORKERS);
    else                                 eff_wrk = ACT_W'(wrk_r);
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    active_nxt    = active_r;
    started_nxt   = started_r;
    admit_nxt     = admit_r;
    halted_nxt    = halted_r;
    cap_nxt       = cap_r;
    wrk_nxt       = wrk_r;
    walk_base_nxt = walk_base_r;
    walk_cnt_nxt  = walk_cnt_r;
    walk_idx_nxt  = walk_idx_r;

    mem_we    = 1'b0;
    mem_waddr = head_r;
    mem_wdata = in_entry;
    mem_re    = 1'b0;
    mem_raddr = head_r;

    emit        = 1'b0;
    emit_last   = 1'b1;
    emit_status = ST_OK;
    emit_tag    = '0;

    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CAPACITY: cap_nxt = cfg_data[CAP_W-1:0];
        CFG_WORKERS:  wrk_nxt = cfg_data[WRK_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_func)
            FN_SUBMIT_BACK, FN_SUBMIT_FRONT, FN_SUBMIT_SUPERSEDE: begin
              if (!admit_r) begin
                emit = 1'b1; emit_status = ST_STOPPING;
              end else if (count_r >= eff_cap) begin
                if (in_func != FN_SUBMIT_SUPERSEDE) begin
                  emit = 1'b1; emit_status = ST_FULL;
                end else begin
                  // read-first store: victim comes back even if the new
                  // head lands on the same entry
                  mem_re    = 1'b1;
                  mem_raddr = slot(head_r, count_m1[PTR_W-1:0]);
                  mem_we    = 1'b1;
                  mem_waddr = prev_slot(head_r);
                  head_nxt  = prev_slot(head_r);
                  state_nxt = S_EVICT;
                end
              end else begin
                mem_we = 1'b1;
                if (in_func == FN_SUBMIT_BACK) begin
                  mem_waddr = slot(head_r, count_r[PTR_W-1:0]);
                end else begin
                  mem_waddr = prev_slot(head_r);
                  head_nxt  = prev_slot(head_r);
                end
                count_nxt   = count_r + 1'b1;
                emit        = 1'b1;
                emit_status = ST_ACCEPTED;
              end
            end
            FN_TAKE: begin
              if (!started_r || halted_r) begin
                emit = 1'b1; emit_status = ST_STOPPING;
              end else if (active_r >= eff_wrk) begin
                emit = 1'b1; emit_status = ST_BUSY;
              end else if (count_r == '0) begin
                emit = 1'b1; emit_status = ST_EMPTY;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = head_r;
                head_nxt   = slot(head_r, PTR_W'(1));
                count_nxt  = count_m1;
                active_nxt = active_r + 1'b1;
                state_nxt  = S_TAKE;
              end
            end
            FN_DONE: begin
              if (active_r != '0) active_nxt = active_r - 1'b1;
              emit = 1'b1; emit_status = ST_OK;
            end
            FN_START: begin
              if (started_r) begin
                emit = 1'b1; emit_status = ST_STARTED;
              end else begin
                started_nxt = 1'b1;
                admit_nxt   = 1'b1;
                halted_nxt  = 1'b0;
                emit = 1'b1; emit_status = ST_OK;
              end
            end
            FN_STOP: begin
              admit_nxt     = 1'b0;
              halted_nxt    = 1'b1;
              count_nxt     = '0;
              head_nxt      = '0;
              walk_base_nxt = head_r;
              walk_cnt_nxt  = count_r;
              walk_idx_nxt  = '0;
              if (count_r == '0) begin
                emit = 1'b1; emit_status = ST_OK;
              end else begin
                state_nxt = S_WALK_RD;
              end
            end
            default: begin
              emit = 1'b1; emit_status = ST_OK;
            end
          endcase
        end
      end
      S_TAKE: begin
        if (out_free) begin
          emit = 1'b1; emit_status = ST_TAKEN; emit_tag = mem_rdata.tag;
          state_nxt = S_IDLE;
        end
      end
      S_EVICT: begin
        if (out_free) begin
          emit = 1'b1;
          if (mem_rdata.cancel) begin
            emit_status = ST_CANCELLED; emit_tag = mem_rdata.tag; emit_last = 1'b0;
            state_nxt   = S_ACCEPT;
          end else begin
            emit_status = ST_ACCEPTED;
            state_nxt   = S_IDLE;
          end
        end
      end
      S_ACCEPT: begin
        if (out_free) begin
          emit = 1'b1; emit_status = ST_ACCEPTED;
          state_nxt = S_IDLE;
        end
      end
      S_WALK_RD: begin
        mem_re    = 1'b1;
        mem_raddr = slot(walk_base_r, walk_idx_r[PTR_W-1:0]);
        state_nxt = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        if (!mem_rdata.cancel || out_free) begin
          if (mem_rdata.cancel) begin
            emit = 1'b1; emit_status = ST_CANCELLED; emit_tag = mem_rdata.tag;
            emit_last = 1'b0;
          end
          walk_idx_nxt = walk_idx_p1;
          state_nxt    = (walk_idx_p1 == walk_cnt_r) ? S_FINAL : S_WALK_RD;
        end
      end
      S_FINAL: begin
        if (out_free) begin
          emit = 1'b1; emit_status = ST_OK;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // output register; snapshot is the state after the whole word
    out_valid_nxt     = out_valid_r && !out_ready;
    out_status_nxt    = out_status_r;
    out_tag_nxt       = out_tag_r;
    out_queued_nxt    = out_queued_r;
    out_active_nxt    = out_active_r;
    out_accepting_nxt = out_accepting_r;
    out_last_nxt      = out_last_r;
    if (emit) begin
      out_valid_nxt     = 1'b1;
      out_status_nxt    = emit_status;
      out_tag_nxt       = emit_tag;
      out_queued_nxt    = count_nxt;
      out_active_nxt    = active_nxt;
      out_accepting_nxt = admit_nxt;
      out_last_nxt      = emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      head_r          <= '0;
      count_r         <= '0;
      active_r        <= '0;
      started_r       <= 1'b0;
      admit_r         <= 1'b0;
      halted_r        <= 1'b0;
      cap_r           <= CAP_W'(16);
      wrk_r           <= WRK_W'(1);
      walk_base_r     <= '0;
      walk_cnt_r      <= '0;
      walk_idx_r      <= '0;
      out_valid_r     <= 1'b0;
      out_status_r    <= ST_OK;
      out_tag_r       <= '0;
      out_queued_r    <= '0;
      out_active_r    <= '0;
      out_accepting_r <= 1'b0;
      out_last_r      <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      head_r          <= head_nxt;
      count_r         <= count_nxt;
      active_r        <= active_nxt;
      started_r       <= started_nxt;
      admit_r         <= admit_nxt;
      halted_r        <= halted_nxt;
      cap_r           <= cap_nxt;
      wrk_r           <= wrk_nxt;
      walk_base_r     <= walk_base_nxt;
      walk_cnt_r      <= walk_cnt_nxt;
      walk_idx_r      <= walk_idx_nxt;
      out_valid_r     <= out_valid_nxt;
      out_status_r    <= out_status_nxt;
      out_tag_r       <= out_tag_nxt;
      out_queued_r    <= out_queued_nxt;
      out_active_r    <= out_active_nxt;
      out_accepting_r <= out_accepting_nxt;
      out_last_r      <= out_last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_tag          = out_tag_r;
  assign out_queued_count = out_queued_r;
  assign out_active_count = out_active_r;
  assign out_accepting    = out_accepting_r;
  assign out_last         = out_last_r;

endmodule

>>> hw/rtl/bpda_store.sv
// ----------------------------------------------------------------------------
// bpda_store
// Entry store: one write port, one read port, registered read data.
// A read and a write to the same entry in one cycle return the old entry.
// ----------------------------------------------------------------------------
module bpda_store
  import bpda_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [PTR_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic             re,
  input  logic [PTR_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/bpda_checker.sv
// ----------------------------------------------------------------------------
// bpda_checker
// Port-level checks for the bounded priority deque admission block.
// ----------------------------------------------------------------------------
module bpda_checker
  import bpda_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [STAT_W-1:0]    out_status,
  input logic [TAG_WIDTH-1:0] out_tag,
  input logic [CNT_W-1:0]     out_queued_count,
  input logic [ACT_W-1:0]     out_active_count,
  input logic                 out_accepting,
  input logic                 out_last
);

  // a stalled result word holds its status, tag and last flag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_tag)
      && $stable(out_last))
    else $error("result word changed while stalled");

  // a cancelled report is never marked last; another word of the same request follows
  a_cancel_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_CANCELLED) |-> !out_last)
    else $error("cancelled word marked last");

  a_accept_snapshot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_ACCEPTED) |-> out_accepting && (out_queued_count != '0))
    else $error("accepted word with closed or empty queue");

  a_taken_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_TAKEN) |-> (out_active_count != '0))
    else $error("taken word with no active task");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_queued_count <= CNT_W'(DEPTH)))
    else $error("queued count beyond depth");

endmodule

bind bounded_priority_deque_admission bpda_checker u_bpda_checker (.*);
